/* design/sspq_pkg.sv */
// shared types and codes for the stable sorted priority queue
package sspq_pkg;

   // field widths fixed by the channel definition
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned PRIO_W = 8;

   // input command codes
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_INSERTED = 2'd0,
      STATUS_DROPPED  = 2'd1,
      STATUS_ENTRY    = 2'd2,
      STATUS_EMPTY    = 2'd3
   } status_type;

   // controller to datapath commands
   typedef struct packed {
      logic insert;       // insert the accepted entry, or drop it when full
      logic report_empty; // answer a drain of an empty store
      logic drain_step;   // emit the head cell and rotate the chain by one
   } ctl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic empty;
      logic drain_last;   // the next drain step emits the final entry
      logic out_stall;    // output register holds a beat that is not taken
   } dp_status_type;

endpackage

/* design/sspq_req_if.sv */
// request channel: valid/ready handshake with command, payload and priority
interface sspq_req_if;
   logic                           valid;
   logic                           ready;
   logic                           cmd;
   logic signed [sspq_pkg::VALUE_W-1:0] data_value;
   logic [sspq_pkg::PRIO_W-1:0]    priority_req;

   modport source (output valid, output cmd, output data_value, output priority_req,
                   input ready);
   modport sink   (input valid, input cmd, input data_value, input priority_req,
                   output ready);
endinterface

/* design/sspq_rsp_if.sv */
// response channel: valid/ready handshake with status and entry fields
interface sspq_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     status;
   logic signed [sspq_pkg::VALUE_W-1:0] entry_value;
   logic [sspq_pkg::PRIO_W-1:0]    entry_priority;
   logic                           last;

   modport source (output valid, output status, output entry_value, output entry_priority,
                   output last, input ready);
   modport sink   (input valid, input status, input entry_value, input entry_priority,
                   input last, output ready);
endinterface

/* design/sspq_ctrl.sv */
// controller state machine: accepts requests and sequences drains
module sspq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_cmd,
   output logic                    req_ready,
   input  sspq_pkg::dp_status_type status,
   output sspq_pkg::ctl_cmd_type   command
);

   typedef enum logic {
      ST_IDLE,
      ST_DRAIN
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE) && !status.out_stall;
   assign accept = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      command = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == sspq_pkg::CMD_INSERT) begin
                  command.insert = 1'b1;
               end else if (status.empty) begin
                  command.report_empty = 1'b1;
               end else begin
                  command.drain_step = 1'b1;
                  if (!status.drain_last) state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (!status.out_stall) begin
               command.drain_step = 1'b1;
               if (status.drain_last) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* design/sspq_datapath.sv */
// sorted cell chain, fill count, drain index and output register
module sspq_datapath #(
   parameter int unsigned CAPACITY = 16,
   parameter int unsigned PRIORITY_BITS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sspq_pkg::ctl_cmd_type                command,
   output sspq_pkg::dp_status_type              status,
   input  logic signed [sspq_pkg::VALUE_W-1:0]  req_data_value,
   input  logic [sspq_pkg::PRIO_W-1:0]          req_priority_req,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic [1:0]                           rsp_status,
   output logic signed [sspq_pkg::VALUE_W-1:0]  rsp_entry_value,
   output logic [sspq_pkg::PRIO_W-1:0]          rsp_entry_priority,
   output logic                                 rsp_last
);

   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
   localparam int unsigned IDX_W = $clog2(CAPACITY);

   logic [sspq_pkg::VALUE_W-1:0] value_ff [CAPACITY];
   logic [sspq_pkg::VALUE_W-1:0] value_in [CAPACITY];
   logic [PRIORITY_BITS-1:0]     prio_ff  [CAPACITY];
   logic [PRIORITY_BITS-1:0]     prio_in  [CAPACITY];
   logic [CAPACITY-1:0]          greater;

   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [PRIORITY_BITS-1:0] new_prio;
   logic full;

   logic                         out_valid_ff, out_valid_in;
   sspq_pkg::status_type         out_status_ff, out_status_in;
   logic [sspq_pkg::VALUE_W-1:0] out_value_ff, out_value_in;
   logic [sspq_pkg::PRIO_W-1:0]  out_prio_ff, out_prio_in;
   logic                         out_last_ff, out_last_in;

   assign new_prio = PRIORITY_BITS'(req_priority_req);
   assign full = (fill_ff == CNT_W'(CAPACITY));

   assign status.empty = (fill_ff == '0);
   assign status.drain_last = ((CNT_W'(idx_ff) + CNT_W'(1)) == fill_ff);
   assign status.out_stall = out_valid_ff && !rsp_ready;

   // each occupied cell compares its priority against the new one
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         greater[i] = (CNT_W'(i) < fill_ff) && (prio_ff[i] > new_prio);
      end
   end

   always_comb begin
      fill_in = fill_ff;
      idx_in = idx_ff;
      for (int i = 0; i < CAPACITY; i++) begin
         value_in[i] = value_ff[i];
         prio_in[i] = prio_ff[i];
      end
      out_valid_in = out_valid_ff && !rsp_ready;
      out_status_in = out_status_ff;
      out_value_in = out_value_ff;
      out_prio_in = out_prio_ff;
      out_last_in = out_last_ff;

      if (command.insert) begin
         out_valid_in = 1'b1;
         out_value_in = '0;
         out_prio_in = '0;
         out_last_in = 1'b1;
         if (full) begin
            out_status_in = sspq_pkg::STATUS_DROPPED;
         end else begin
            out_status_in = sspq_pkg::STATUS_INSERTED;
            fill_in = fill_ff + CNT_W'(1);
            // cells above the insertion point shift up, the first one takes the new entry
            for (int i = 0; i < CAPACITY; i++) begin
               if (greater[i]) begin
                  if (i > 0 && greater[(i > 0) ? i - 1 : 0]) begin
                     value_in[i] = value_ff[(i > 0) ? i - 1 : 0];
                     prio_in[i] = prio_ff[(i > 0) ? i - 1 : 0];
                  end else begin
                     value_in[i] = req_data_value;
                     prio_in[i] = new_prio;
                  end
               end else if (CNT_W'(i) == fill_ff) begin
                  if (i > 0 && greater[(i > 0) ? i - 1 : 0]) begin
                     value_in[i] = value_ff[(i > 0) ? i - 1 : 0];
                     prio_in[i] = prio_ff[(i > 0) ? i - 1 : 0];
                  end else begin
                     value_in[i] = req_data_value;
                     prio_in[i] = new_prio;
                  end
               end
            end
         end
      end else if (command.report_empty) begin
         out_valid_in = 1'b1;
         out_status_in = sspq_pkg::STATUS_EMPTY;
         out_value_in = '0;
         out_prio_in = '0;
         out_last_in = 1'b1;
      end else if (command.drain_step) begin
         out_valid_in = 1'b1;
         out_status_in = sspq_pkg::STATUS_ENTRY;
         out_value_in = value_ff[0];
         out_prio_in = sspq_pkg::PRIO_W'(prio_ff[0]);
         out_last_in = status.drain_last;
         idx_in = status.drain_last ? '0 : idx_ff + IDX_W'(1);
         // rotate the occupied cells so the next entry reaches the head
         for (int i = 0; i < CAPACITY; i++) begin
            if ((CNT_W'(i) + CNT_W'(1)) == fill_ff) begin
               value_in[i] = value_ff[0];
               prio_in[i] = prio_ff[0];
            end else if ((CNT_W'(i) + CNT_W'(1)) < fill_ff) begin
               value_in[i] = value_ff[(i + 1 < CAPACITY) ? i + 1 : i];
               prio_in[i] = prio_ff[(i + 1 < CAPACITY) ? i + 1 : i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         idx_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         idx_ff <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         value_ff[i] <= value_in[i];
         prio_ff[i] <= prio_in[i];
      end
      out_status_ff <= out_status_in;
      out_value_ff <= out_value_in;
      out_prio_ff <= out_prio_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_status = out_status_ff;
   assign rsp_entry_value = out_value_ff;
   assign rsp_entry_priority = out_prio_ff;
   assign rsp_last = out_last_ff;

endmodule

/* design/stable_sorted_priority_queue_top.sv */
// top level of the stable sorted priority queue
//
//  channel   dir  beat contents
//  req_chan  in   cmd, data_value, priority_req
//  rsp_chan  out  status, entry_value, entry_priority, last
//
// an insert compares every cell's priority with the new one in
// parallel and the cells above the insertion point shift up in the same edge
// a drain emits fill-count beats (one if empty), one per cycle unless output stalls,
// rotating the occupied cells through the head so the order is restored at the end
// no new request is taken while a drain is running
// the output register frees the chain from the consumer; a stalled beat holds
// synchronous reset clears the fill count, the drain index and the handshake state only
module stable_sorted_priority_queue_top #(
   parameter int unsigned CAPACITY = 16,
   parameter int unsigned PRIORITY_BITS = 8
) (
   input logic       clock,
   input logic       reset,
   sspq_req_if.sink  req_chan,
   sspq_rsp_if.source rsp_chan
);

   sspq_pkg::ctl_cmd_type   command;
   sspq_pkg::dp_status_type status;

   // sequencing of request acceptance and drain steps
   sspq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_cmd   (req_chan.cmd),
      .req_ready (req_chan.ready),
      .status    (status),
      .command   (command)
   );

   // cell chain and output register
   sspq_datapath #(
      .CAPACITY      (CAPACITY),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .command            (command),
      .status             (status),
      .req_data_value     (req_chan.data_value),
      .req_priority_req   (req_chan.priority_req),
      .rsp_ready          (rsp_chan.ready),
      .rsp_valid          (rsp_chan.valid),
      .rsp_status         (rsp_chan.status),
      .rsp_entry_value    (rsp_chan.entry_value),
      .rsp_entry_priority (rsp_chan.entry_priority),
      .rsp_last           (rsp_chan.last)
   );

endmodule
